// File: hw/rtl/tdaf_pkg.sv
// Shared types, constants and codes for the trial-division arithmetic block.
package tdaf_pkg;

    localparam int A_BITS         = 41;   // answer width, signed
    localparam int DATA_BITS      = 32;   // width of the number field
    localparam int KIND_BITS      = 3;
    localparam int VALUE_BITS_DEF = 32;
    localparam int OMEGA_BITS     = 6;

    // function selectors carried in tuser
    localparam logic [KIND_BITS-1:0] K_OMEGA    = 3'd0;
    localparam logic [KIND_BITS-1:0] K_PHI      = 3'd1;
    localparam logic [KIND_BITS-1:0] K_RADICAL  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_MU       = 3'd3;
    localparam logic [KIND_BITS-1:0] K_DCOUNT   = 3'd4;
    localparam logic [KIND_BITS-1:0] K_SIGMA    = 3'd5;
    localparam logic [KIND_BITS-1:0] K_IS_PRIME = 3'd6;
    localparam logic [KIND_BITS-1:0] K_SMALLEST = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DSTART,
        S_DWAIT,
        S_MSTART,
        S_MWAIT,
        S_FINISH
    } t_state;

    // multiply jobs run on the shared unit
    typedef enum logic [2:0] {
        M_PW,
        M_PHI_A,
        M_PHI_B,
        M_RAD,
        M_DC,
        M_SG
    } t_mop;

    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [A_BITS-1:0] a;
        logic [A_BITS-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic              done;
        logic [A_BITS-1:0] res;   // product, or quotient in the low bits
        logic [A_BITS-1:0] rem;   // remainder of a division
    } t_unit_rsp;

endpackage

// File: hw/rtl/tdaf_unit.sv
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit a cycle.
module tdaf_unit #(
    parameter int VALUE_BITS = tdaf_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdaf_pkg::t_unit_req i_req,
    output tdaf_pkg::t_unit_rsp o_rsp
);
    import tdaf_pkg::*;

    localparam int W      = (VALUE_BITS > DATA_BITS) ? DATA_BITS : VALUE_BITS;
    localparam int CNT_W  = $clog2(A_BITS + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [A_BITS-1:0] r_acc;
    logic [A_BITS-1:0] r_x;
    logic [A_BITS-1:0] r_y;

    logic [W:0] trial;
    logic       ge;

    // one restoring-division step on the low W bits
    always_comb begin
        trial = {r_acc[W-1:0], r_x[W-1]};
        ge    = (trial >= {1'b0, r_y[W-1:0]});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_acc <= '0;
            r_x   <= i_req.a;
            r_y   <= i_req.b;
            r_cnt <= i_req.is_div ? CNT_W'(W - 1) : CNT_W'(A_BITS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_div) begin
                r_acc <= A_BITS'(ge ? (trial - {1'b0, r_y[W-1:0]}) : trial);
                r_x   <= {r_x[A_BITS-2:0], ge};
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[A_BITS-2:0], 1'b0};
                r_y <= {1'b0, r_y[A_BITS-1:1]};
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.res  = r_div ? A_BITS'(r_x[W-1:0]) : r_acc;
        o_rsp.rem  = r_acc;
    end

    // a new job never lands on a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("unit restarted while busy");
    // done follows the last step only
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("unit done while busy");
    a_no_done_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> !r_done) else $error("unit done right after start");

endmodule

// File: hw/rtl/trial_division_arith_functions_core.sv
// Top level: trial-division sequencer over the shared multiply/divide unit.
//
//  channel | dir | tdata                     | tuser
//  s_axis  | in  | [31:0] number             | [2:0] kind
//  m_axis  | out | [40:0] answer (signed)    | [0] status
//
// Cost: each trial divisor costs one W-step division on the shared unit
// (W = min(VALUE_BITS,32)); each prime factor found adds one multiply and
// one more division per power, and five multiplies to fold it in. A 32-bit
// prime takes about 32768 divisors. n=0 goes to the result without trial division.
// Reset clears the sequencer and the output valid; no clearing pass.
// s_axis_tready is high only when idle; a finished result waits in the
// output register while the next number is taken.
module trial_division_arith_functions_core #(
    parameter int VALUE_BITS = tdaf_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tdaf_pkg::DATA_BITS-1:0] s_axis_tdata,   // [31:0] number
    input  logic [tdaf_pkg::KIND_BITS-1:0] s_axis_tuser,   // [2:0] kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,   // [40:0] answer, rest zero
    output logic [0:0]                    m_axis_tuser    // [0] status
);
    import tdaf_pkg::*;

    localparam int W   = (VALUE_BITS > DATA_BITS) ? DATA_BITS : VALUE_BITS;
    localparam int V_W = $clog2(W + 1);

    t_state r_state, n_state;
    t_mop   r_mop, n_mop;
    logic   r_ovalid, n_ovalid;

    logic [KIND_BITS-1:0]  r_kind, n_kind;
    logic [W-1:0]          r_n, n_n, r_rest, n_rest, r_div, n_div, r_p, n_p;
    logic [W-1:0]          r_first, n_first;
    logic [2*W-1:0]        r_sq, n_sq;
    logic [V_W-1:0]        r_v, n_v;
    logic [OMEGA_BITS-1:0] r_omega, n_omega;
    logic [A_BITS-1:0]     r_pw, n_pw, r_pwm, n_pwm, r_s, n_s;
    logic [A_BITS-1:0]     r_phi, n_phi, r_rad, n_rad, r_dc, n_dc, r_sg, n_sg;
    logic                  r_mu_neg, n_mu_neg, r_mu_zero, n_mu_zero;
    logic [A_BITS-1:0]     r_oans, n_oans;
    logic                  r_ostat, n_ostat;

    t_unit_req unit_req;
    t_unit_rsp unit_rsp;

    logic              accept;
    logic [W-1:0]      in_n;
    logic [A_BITS-1:0] answer;
    logic              status;

    tdaf_unit #(.VALUE_BITS(VALUE_BITS)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_n   = s_axis_tdata[W-1:0];

    // form the selected function from the factor summary
    always_comb begin
        answer = '0;
        status = 1'b0;
        if (r_n == '0) begin
            status = (r_kind != K_IS_PRIME);
        end else begin
            unique case (r_kind)
                K_OMEGA:    answer = A_BITS'(r_omega);
                K_PHI:      answer = r_phi;
                K_RADICAL:  answer = r_rad;
                K_MU:       answer = r_mu_zero ? '0 : (r_mu_neg ? '1 : A_BITS'(1));
                K_DCOUNT:   answer = r_dc;
                K_SIGMA:    answer = r_sg;
                K_IS_PRIME: answer = A_BITS'((r_n > W'(1)) && (r_first == r_n));
                K_SMALLEST: begin
                    if (r_n < W'(2)) begin
                        status = 1'b1;
                    end else begin
                        answer = A_BITS'(r_first);
                    end
                end
                default: answer = '0;
            endcase
        end
    end

    // sequencer: next state and unit requests
    always_comb begin
        n_state = r_state;   n_mop = r_mop;       n_ovalid = r_ovalid;
        n_kind = r_kind;     n_n = r_n;           n_rest = r_rest;
        n_div = r_div;       n_p = r_p;           n_first = r_first;
        n_sq = r_sq;         n_v = r_v;           n_omega = r_omega;
        n_pw = r_pw;         n_pwm = r_pwm;       n_s = r_s;
        n_phi = r_phi;       n_rad = r_rad;       n_dc = r_dc;
        n_sg = r_sg;         n_mu_neg = r_mu_neg; n_mu_zero = r_mu_zero;
        n_oans = r_oans;     n_ostat = r_ostat;

        unit_req.start  = 1'b0;
        unit_req.is_div = 1'b0;
        unit_req.a      = '0;
        unit_req.b      = '0;

        s_axis_tready = (r_state == S_IDLE);

        // drop the output once taken
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = s_axis_tuser;
                    n_n = in_n;          n_rest = in_n;
                    n_div = W'(2);       n_sq = (2*W)'(4);
                    n_first = '0;        n_omega = '0;
                    n_phi = A_BITS'(1);  n_rad = A_BITS'(1);
                    n_dc = A_BITS'(1);   n_sg = A_BITS'(1);
                    n_mu_neg = 1'b0;     n_mu_zero = 1'b0;
                    n_v = '0;            n_pw = A_BITS'(1);
                    n_pwm = A_BITS'(1);  n_s = A_BITS'(1);
                    n_state = (in_n == '0) ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rest <= W'(1)) begin
                    n_state = S_FINISH;
                end else if (r_sq <= (2*W)'(r_rest)) begin
                    n_p     = r_div;
                    n_state = S_DSTART;
                end else begin
                    // leftover is one more prime
                    n_p     = r_rest;
                    n_v     = V_W'(1);
                    n_pwm   = A_BITS'(1);
                    n_pw    = A_BITS'(r_rest);
                    n_s     = A_BITS'(r_rest) + A_BITS'(1);
                    n_rest  = W'(1);
                    n_mop   = M_PHI_A;
                    n_state = S_MSTART;
                end
            end
            S_DSTART: begin
                unit_req.start  = 1'b1;
                unit_req.is_div = 1'b1;
                unit_req.a      = A_BITS'(r_rest);
                unit_req.b      = A_BITS'(r_div);
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (unit_rsp.done) begin
                    if (unit_rsp.rem[W-1:0] == '0) begin
                        n_v     = r_v + 1'b1;
                        n_pwm   = r_pw;
                        n_rest  = unit_rsp.res[W-1:0];
                        n_mop   = M_PW;
                        n_state = S_MSTART;
                    end else if (r_v != '0) begin
                        n_mop   = M_PHI_A;
                        n_state = S_MSTART;
                    end else begin
                        // advance to the next trial divisor
                        n_div   = (r_div == W'(2)) ? W'(3) : r_div + W'(2);
                        n_sq    = (r_div == W'(2)) ? r_sq + (2*W)'(5)
                                                   : r_sq + ((2*W)'(r_div) << 2) + (2*W)'(4);
                        n_state = S_CHECK;
                    end
                end
            end
            S_MSTART: begin
                unit_req.start = 1'b1;
                unique case (r_mop)
                    M_PW:    begin unit_req.a = r_pw;  unit_req.b = A_BITS'(r_p); end
                    M_PHI_A: begin unit_req.a = r_phi; unit_req.b = r_pwm; end
                    M_PHI_B: begin
                        unit_req.a = r_phi;
                        unit_req.b = A_BITS'(r_p) - A_BITS'(1);
                    end
                    M_RAD:   begin unit_req.a = r_rad; unit_req.b = A_BITS'(r_p); end
                    M_DC:    begin
                        unit_req.a = r_dc;
                        unit_req.b = A_BITS'(r_v) + A_BITS'(1);
                    end
                    M_SG:    begin unit_req.a = r_sg;  unit_req.b = r_s; end
                    default: begin unit_req.a = '0;    unit_req.b = '0; end
                endcase
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (unit_rsp.done) begin
                    n_state = S_MSTART;
                    unique case (r_mop)
                        M_PW: begin
                            n_pw    = unit_rsp.res;
                            n_s     = r_s + unit_rsp.res;
                            n_state = S_DSTART;
                        end
                        M_PHI_A: begin n_phi = unit_rsp.res; n_mop = M_PHI_B; end
                        M_PHI_B: begin n_phi = unit_rsp.res; n_mop = M_RAD; end
                        M_RAD: begin
                            n_rad   = unit_rsp.res;
                            n_omega = r_omega + 1'b1;
                            if (r_first == '0) begin
                                n_first = r_p;
                            end
                            if (r_v >= V_W'(2)) begin
                                n_mu_zero = 1'b1;
                            end else begin
                                n_mu_neg = !r_mu_neg;
                            end
                            n_mop = M_DC;
                        end
                        M_DC: begin n_dc = unit_rsp.res; n_mop = M_SG; end
                        M_SG: begin
                            n_sg    = unit_rsp.res;
                            n_v     = '0;
                            n_pw    = A_BITS'(1);
                            n_pwm   = A_BITS'(1);
                            n_s     = A_BITS'(1);
                            n_div   = (r_div == W'(2)) ? W'(3) : r_div + W'(2);
                            n_sq    = (r_div == W'(2)) ? r_sq + (2*W)'(5)
                                                       : r_sq + ((2*W)'(r_div) << 2) + (2*W)'(4);
                            n_state = S_CHECK;
                        end
                        default: n_state = S_CHECK;
                    endcase
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_ovalid) begin
                    n_oans   = answer;
                    n_ostat  = status;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mop <= n_mop;       r_kind <= n_kind;     r_n <= n_n;
        r_rest <= n_rest;     r_div <= n_div;       r_p <= n_p;
        r_first <= n_first;   r_sq <= n_sq;         r_v <= n_v;
        r_omega <= n_omega;   r_pw <= n_pw;         r_pwm <= n_pwm;
        r_s <= n_s;           r_phi <= n_phi;       r_rad <= n_rad;
        r_dc <= n_dc;         r_sg <= n_sg;         r_mu_neg <= n_mu_neg;
        r_mu_zero <= n_mu_zero;
        r_oans <= n_oans;     r_ostat <= n_ostat;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_oans};
    assign m_axis_tuser  = r_ostat;

    // zero finishes without any trial division
    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_n == '0) |=> (r_state == S_FINISH)) else $error("zero not short-cut");
    // factoring is complete when the result is formed
    a_rest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_n != '0) |-> (r_rest <= W'(1)))
        else $error("finish with unfactored rest");
    // the unit is quiet while idle
    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !unit_rsp.done) else $error("unit done while idle");
    // a result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_ovalid) |=> (r_state == S_FINISH || !r_ovalid
                                               || $past(m_axis_tready)))
        else $error("output overwritten");

endmodule
